// ----- src/mlrd_pkg.sv -----
package mlrd_pkg;

	// Parser modes. Code 3 is never entered; if it were, it behaves as search.
	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_LENGTH = 2'd1,
		MODE_SKIP   = 2'd2
	} mode_t;

	// Magic value after reset. The first stream byte lands in bits 7..0.
	localparam logic [31:0] MAGIC_RESET = 32'hE5E9E8E6;

	// Bytes in one gathered word, and the phase of its last byte.
	localparam int unsigned WORD_BYTES = 4;
	localparam logic [1:0] PHASE_LAST = 2'(WORD_BYTES - 1);

	// Result of one parsed byte, handed from the parser to the output register.
	typedef struct packed {
		logic        hit;
		logic [31:0] block_number;
		logic [31:0] start_offset;
	} result_t;

endpackage

// ----- src/magic_length_record_deframer_top.sv -----
// Channel   Direction  Word                                    Handshake
// s_axis    in         tdata[7:0] data_byte                    tvalid/tready
// m_axis    out        tdata[31:0] block_number,               tvalid/tready
//                      tdata[63:32] start_offset
// cfg       in         cfg_data[31:0] magic_word               cfg_valid/cfg_ready
//
// One byte is taken per cycle while the output is not stalled; a byte sits in the input register
// until the parser steps on it, and its result, if any, is then loaded into the output register.
// The rate is set by the single parse step between the two registers: one byte a cycle unless the output stalls.
// Reset clears the parser state and loads the default magic; no clearing pass is needed.
// While a result waits in a stalled output register the parser holds, so the input
// register keeps its byte and the input stalls until the result word is taken.
module magic_length_record_deframer_top #(
	parameter int unsigned OFFSET_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] block_number, [63:32] start_offset
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data        // [31:0] magic_word
);

	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               advance;
	logic [31:0]        magic_q;
	mlrd_pkg::result_t  result;
	logic               out_valid_q;
	logic [63:0]        out_data_q;

	// The parser steps when a byte waits and the output register can take a result.
	assign advance = valid_s1 && (!out_valid_q || m_axis_tready);

	mlrd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	mlrd_parse #(
		.OFFSET_WIDTH (OFFSET_WIDTH)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.magic_word (magic_q),
		.result     (result)
	);

	// Magic register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= mlrd_pkg::MAGIC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			magic_q <= cfg_data;
		end
	end

	// Output register flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result.hit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (result.hit) begin
			out_data_q <= {result.start_offset, result.block_number};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// A result word never carries block number zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[31:0] != 32'd0))
		else $error("result word with block number zero");

	// A held result and a waiting byte leave no room for another input word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
		else $error("input accepted while pipeline is full");

	// An empty output register fills only from a parser step.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |=> (!out_valid_q || $past(advance)))
		else $error("result appeared without a parser step");

endmodule

// ----- src/mlrd_in_stage.sv -----
module mlrd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic       valid_q;
	logic [7:0] byte_q;

	// The stage takes a new word whenever it is empty or its word moves on.
	assign in_ready = !valid_q || advance;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Payload register, loaded only on an accepted word.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_q <= in_byte;
		end
	end

	assign valid_s1 = valid_q;
	assign byte_s1  = byte_q;

endmodule

// ----- src/mlrd_parse.sv -----
module mlrd_parse #(
	parameter int unsigned OFFSET_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic [31:0]            magic_word,
	output mlrd_pkg::result_t      result
);

	mlrd_pkg::mode_t           mode_q, mode_d;
	logic [1:0]                phase_q, phase_d;
	logic [31:0]               gather_q, gather_d;
	logic [31:0]               skip_q, skip_d;
	logic [OFFSET_WIDTH-1:0]   offset_q, offset_d;
	logic [31:0]               count_q, count_d;

	logic [31:0]               gathered;
	logic                      word_done;
	logic [31:0]               skip_dec;
	logic                      magic_hit;
	logic [OFFSET_WIDTH+31:0]  offset_ext;

	// Shared decode of the current byte.
	always_comb begin
		gathered   = gather_q | ({24'd0, data_byte} << {phase_q, 3'b000});
		word_done  = (phase_q == mlrd_pkg::PHASE_LAST);
		skip_dec   = (skip_q != 32'd0) ? skip_q - 32'd1 : skip_q;
		magic_hit  = word_done && (gathered == magic_word);
		offset_d   = (offset_q != '1) ? offset_q + OFFSET_WIDTH'(1) : offset_q;
		offset_ext = {32'd0, offset_d};
	end

	// Next parser mode.
	always_comb begin
		mode_d = mode_q;
		case (mode_q)
			mlrd_pkg::MODE_SKIP: begin
				if (skip_dec == 32'd0) begin
					mode_d = mlrd_pkg::MODE_SEARCH;
				end
			end
			mlrd_pkg::MODE_LENGTH: begin
				if (word_done) begin
					mode_d = (gathered != 32'd0) ? mlrd_pkg::MODE_SKIP : mlrd_pkg::MODE_SEARCH;
				end
			end
			default: begin
				if (word_done) begin
					mode_d = magic_hit ? mlrd_pkg::MODE_LENGTH : mlrd_pkg::MODE_SEARCH;
				end
			end
		endcase
	end

	// Datapath updates and the result of this byte.
	always_comb begin
		phase_d  = phase_q;
		gather_d = gather_q;
		skip_d   = skip_q;
		count_d  = count_q;
		result   = '0;
		case (mode_q)
			mlrd_pkg::MODE_SKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 32'd0) begin
					phase_d  = 2'd0;
					gather_d = 32'd0;
				end
			end
			mlrd_pkg::MODE_LENGTH: begin
				phase_d  = phase_q + 2'd1;
				gather_d = word_done ? 32'd0 : gathered;
				if (word_done) begin
					skip_d = gathered;
				end
			end
			default: begin
				phase_d  = phase_q + 2'd1;
				gather_d = word_done ? 32'd0 : gathered;
				if (magic_hit) begin
					count_d = (count_q != '1) ? count_q + 32'd1 : count_q;
					result.hit          = 1'b1;
					result.block_number = count_d;
					result.start_offset = (offset_ext[OFFSET_WIDTH+31:32] != '0) ?
						32'hFFFF_FFFF : offset_ext[31:0];
				end
			end
		endcase
		result.hit = result.hit && step;
	end

	// Parser state, updated once per byte that moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= mlrd_pkg::MODE_SEARCH;
			phase_q  <= 2'd0;
			gather_q <= 32'd0;
			skip_q   <= 32'd0;
			offset_q <= '0;
			count_q  <= 32'd0;
		end else if (step) begin
			mode_q   <= mode_d;
			phase_q  <= phase_d;
			gather_q <= gather_d;
			skip_q   <= skip_d;
			offset_q <= offset_d;
			count_q  <= count_d;
		end
	end

endmodule
